>>> rtl/mexp_pkg.sv
// Package for the modular exponentiation block.
// Holds field widths, register map, codes and the sequencer state type.
// No dependencies.
package mexp_pkg;

   localparam int MOD_WIDTH_DEF = 32;
   localparam int EXP_WIDTH_DEF = 64;

   localparam int BASE_W      = 32;
   localparam int EXP_FIELD_W = 64;
   localparam int RESULT_W    = 32;
   localparam int REQ_DATA_W  = BASE_W + EXP_FIELD_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_DATA_W-1:0] MODULUS_RESET = 32'd1000000007;
   localparam int                    FERMAT_OFFSET = 2;

   // register index, taken from paddr[2]
   localparam logic REG_MODULUS = 1'b0;

   localparam logic ACT_POWER   = 1'b0;
   localparam logic ACT_INVERSE = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_BADMOD = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RBASE,
      ST_STEP,
      ST_MULA,
      ST_MULS,
      ST_OUT
   } state_type;

endpackage

>>> rtl/mexp_mulmod.sv
// Shared modular multiply unit: one registered multiply, then a
// shift-subtract reduction two product bits per cycle. Uses mexp_pkg.
module mexp_mulmod #(
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mexp_pkg::BASE_W-1:0] op_a,
   input  logic [MOD_WIDTH-1:0]        op_b,
   input  logic [MOD_WIDTH-1:0]        modulus,
   output logic                        busy,
   output logic                        done,
   output logic [MOD_WIDTH-1:0]        result
);

   localparam int PW_RAW = mexp_pkg::BASE_W + MOD_WIDTH;
   localparam int PW     = PW_RAW + (PW_RAW % 2);
   localparam int STEPS  = PW / 2;
   localparam int CW     = $clog2(STEPS + 1);

   logic [mexp_pkg::BASE_W-1:0] opa_ff, opa_in;
   logic [MOD_WIDTH-1:0]        opb_ff, opb_in;
   logic [MOD_WIDTH-1:0]        mod_ff, mod_in;
   logic [PW-1:0]               prod_ff, prod_in;
   logic [MOD_WIDTH-1:0]        rem_ff, rem_in;
   logic [MOD_WIDTH-1:0]        res_ff, res_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        mul_ff, mul_in;
   logic                        done_ff, done_in;

   logic [MOD_WIDTH:0]   t1, t2, m_ext;
   logic [MOD_WIDTH-1:0] r1, r2;
   logic [PW_RAW-1:0]    prod_raw;

   assign m_ext    = {1'b0, mod_ff};
   assign t1       = {rem_ff, prod_ff[PW-1]};
   assign r1       = (t1 >= m_ext) ? MOD_WIDTH'(t1 - m_ext) : t1[MOD_WIDTH-1:0];
   assign t2       = {r1, prod_ff[PW-2]};
   assign r2       = (t2 >= m_ext) ? MOD_WIDTH'(t2 - m_ext) : t2[MOD_WIDTH-1:0];
   assign prod_raw = PW_RAW'(opa_ff) * PW_RAW'(opb_ff);

   always_comb begin
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      mod_in  = mod_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      mul_in  = mul_ff;
      done_in = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            opa_in  = op_a;
            opb_in  = op_b;
            mod_in  = modulus;
            busy_in = 1'b1;
            mul_in  = 1'b1;
         end
      end else if (mul_ff) begin
         prod_in = PW'(prod_raw);
         rem_in  = '0;
         cnt_in  = CW'(STEPS);
         mul_in  = 1'b0;
      end else begin
         rem_in  = r2;
         prod_in = {prod_ff[PW-3:0], 2'b00};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = r2;
         end
      end
   end

   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      mod_ff  <= mod_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = res_ff;

   a_res_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff && mod_ff != '0 |-> res_ff < mod_ff)
      else $error("mulmod result not below modulus");

   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !mul_ff && mod_ff != '0 |-> rem_ff < mod_ff)
      else $error("partial remainder escaped range");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a preceding reduction");

endmodule

>>> rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: stream ports, modulus
// register on an APB-style port, square-and-multiply sequencer.
// Uses mexp_pkg and mexp_mulmod.
//
// Computes base^exponent mod modulus (tuser 0) or the Fermat inverse
// base^(modulus-2) mod modulus (tuser 1) by right-to-left square and
// multiply. One word is in flight at a time; req_tready stays low while it
// is worked on. All arithmetic goes through one mulmod unit: a registered
// multiply, then a shift-subtract reduction. The base is first reduced
// with one pass of that unit; then each exponent bit up to the highest set
// one costs a step plus a multiply and a square, or a step and a square
// when the bit is clear; the top bit skips its square. An exponent of 0
// still reduces the base. Words rejected at once (modulus 0 in power mode,
// modulus below 2 in inverse mode) skip the mulmod unit. A stalled
// rsp_tready holds the block in its output state. The modulus register is
// read at each accepted word; write it only while the block is idle.
module modular_exponentiation #(
   parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
   parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request word
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] base, [95:32] exponent
   input  logic [mexp_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] action
   input  logic                            req_tuser,
   // response word
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] result
   output logic [mexp_pkg::RESULT_W-1:0]   rsp_tdata,
   // [0] status
   output logic                            rsp_tuser,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mexp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mexp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mexp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int EW = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;

   mexp_pkg::state_type state_ff, state_in;

   logic [mexp_pkg::CSR_DATA_W-1:0] modulus_ff;
   logic [MOD_WIDTH-1:0]            mod_ff, mod_in;
   logic                            act_ff, act_in;
   logic [mexp_pkg::BASE_W-1:0]     base_ff, base_in;
   logic [EW-1:0]                   exp_ff, exp_in;
   logic [MOD_WIDTH-1:0]            acc_ff, acc_in;
   logic [MOD_WIDTH-1:0]            sq_ff, sq_in;
   logic                            status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mexp_pkg::RESULT_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic                            mm_start, mm_busy, mm_done;
   logic [mexp_pkg::BASE_W-1:0]     mm_a;
   logic [MOD_WIDTH-1:0]            mm_b, mm_res;

   logic                            req_take, csr_write, out_free;
   logic [EW-1:0]                   exp_next;

   assign req_take  = req_tvalid && req_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign exp_next  = exp_ff >> 1;

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == mexp_pkg::REG_MODULUS) ? modulus_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= mexp_pkg::MODULUS_RESET;
      end else if (csr_write && csr_paddr[2] == mexp_pkg::REG_MODULUS) begin
         modulus_ff <= csr_pwdata;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (req_take) state_in = mexp_pkg::ST_PREP;
         end
         mexp_pkg::ST_PREP: begin
            if ((act_ff == mexp_pkg::ACT_POWER && mod_ff == '0) ||
                (act_ff == mexp_pkg::ACT_INVERSE &&
                 mod_ff < MOD_WIDTH'(mexp_pkg::FERMAT_OFFSET)))
               state_in = mexp_pkg::ST_OUT;
            else
               state_in = mexp_pkg::ST_RBASE;
         end
         mexp_pkg::ST_RBASE: begin
            if (mm_done) state_in = mexp_pkg::ST_STEP;
         end
         mexp_pkg::ST_STEP: begin
            if (exp_ff == '0)
               state_in = mexp_pkg::ST_OUT;
            else if (exp_ff[0])
               state_in = mexp_pkg::ST_MULA;
            else
               state_in = mexp_pkg::ST_MULS;
         end
         mexp_pkg::ST_MULA: begin
            if (mm_done) begin
               if (exp_next != '0) state_in = mexp_pkg::ST_MULS;
               else                state_in = mexp_pkg::ST_OUT;
            end
         end
         mexp_pkg::ST_MULS: begin
            if (mm_done) state_in = mexp_pkg::ST_STEP;
         end
         mexp_pkg::ST_OUT: begin
            if (out_free) state_in = mexp_pkg::ST_IDLE;
         end
         default: state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_tready   = 1'b0;
      mm_start     = 1'b0;
      mm_a         = mexp_pkg::BASE_W'(sq_ff);
      mm_b         = sq_ff;
      mod_in       = mod_ff;
      act_in       = act_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_take) begin
               act_in    = req_tuser;
               base_in   = req_tdata[mexp_pkg::BASE_W-1:0];
               exp_in    = EW'(req_tdata[mexp_pkg::BASE_W +: EXP_WIDTH]);
               mod_in    = modulus_ff[MOD_WIDTH-1:0];
               status_in = mexp_pkg::STATUS_OK;
            end
         end
         mexp_pkg::ST_PREP: begin
            if (act_ff == mexp_pkg::ACT_POWER && mod_ff == '0) begin
               acc_in = '0;
            end else if (act_ff == mexp_pkg::ACT_INVERSE &&
                         mod_ff < MOD_WIDTH'(mexp_pkg::FERMAT_OFFSET)) begin
               acc_in    = '0;
               status_in = mexp_pkg::STATUS_BADMOD;
            end else begin
               if (act_ff == mexp_pkg::ACT_INVERSE)
                  exp_in = EW'(mod_ff - MOD_WIDTH'(mexp_pkg::FERMAT_OFFSET));
               acc_in   = (mod_ff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
               // base mod m as base * 1
               mm_start = 1'b1;
               mm_a     = base_ff;
               mm_b     = MOD_WIDTH'(1);
            end
         end
         mexp_pkg::ST_RBASE: begin
            if (mm_done) sq_in = mm_res;
         end
         mexp_pkg::ST_STEP: begin
            if (exp_ff != '0) begin
               mm_start = 1'b1;
               if (exp_ff[0]) begin
                  mm_a = mexp_pkg::BASE_W'(acc_ff);
               end else begin
                  exp_in = exp_next;
               end
            end
         end
         mexp_pkg::ST_MULA: begin
            if (mm_done) begin
               acc_in = mm_res;
               exp_in = exp_next;
               // square only if higher exponent bits remain
               if (exp_next != '0) mm_start = 1'b1;
            end
         end
         mexp_pkg::ST_MULS: begin
            if (mm_done) sq_in = mm_res;
         end
         mexp_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mexp_pkg::RESULT_W'(acc_ff);
               rsp_user_in  = status_ff;
            end
         end
         default: begin
            mm_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mod_ff      <= mod_in;
      act_ff      <= act_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= mexp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   mexp_mulmod #(
      .MOD_WIDTH(MOD_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (mod_ff),
      .busy    (mm_busy),
      .done    (mm_done),
      .result  (mm_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_busy)
      else $error("mulmod started while busy");

   a_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      mm_busy |-> state_ff == mexp_pkg::ST_RBASE || state_ff == mexp_pkg::ST_MULA ||
                  state_ff == mexp_pkg::ST_MULS)
      else $error("mulmod busy outside a wait state");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == mexp_pkg::ST_STEP |-> acc_ff < mod_ff)
      else $error("accumulator not below modulus");

   a_badmod_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff == mexp_pkg::STATUS_BADMOD |-> rsp_data_ff == '0)
      else $error("error word carries a nonzero result");

endmodule

>>> tb/tb_modular_exponentiation.sv
// Self-checking testbench for the modular exponentiation block.
// Drives the request stream and the modulus register and checks each response word.
// Depends on mexp_pkg and modular_exponentiation.
module tb_modular_exponentiation;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [mexp_pkg::RESULT_W-1:0] result;
      logic                          status;
   } outcome_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   // [31:0] base, [95:32] exponent
   logic [mexp_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   // [0] action
   logic                            req_tuser   = mexp_pkg::ACT_POWER;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   // [31:0] result
   logic [mexp_pkg::RESULT_W-1:0]   rsp_tdata;
   // [0] status
   logic                            rsp_tuser;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [mexp_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [mexp_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [mexp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   logic [mexp_pkg::CSR_DATA_W-1:0] modulus_model = mexp_pkg::MODULUS_RESET;
   outcome_type                     pending_outcomes[$];
   int                              mismatch_count = 0;
   int                              words_checked  = 0;
   int                              cycle_count    = 0;
   int                              send_idle_pct  = 16;
   int                              recv_stall_pct = 84;

   modular_exponentiation DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // right-to-left square and multiply; operands below m < 2^32 keep products exact
   function automatic bit [63:0] power_mod(bit [63:0] b, bit [63:0] e, bit [63:0] m);
      bit [63:0] acc;
      bit [63:0] sq;
      bit [63:0] rest;
      acc  = 64'd1 % m;
      sq   = b % m;
      rest = e;
      while (rest != 64'd0) begin
         if (rest[0])
            acc = (acc * sq) % m;
         rest = rest >> 1;
         sq   = (sq * sq) % m;
      end
      return acc;
   endfunction

   function automatic outcome_type modexp_outcome(logic action, logic [31:0] base,
                                                  logic [63:0] exponent,
                                                  logic [31:0] modulus);
      outcome_type o;
      bit [63:0]   m;
      m        = {32'd0, modulus};
      o.result = '0;
      o.status = mexp_pkg::STATUS_OK;
      if (action == mexp_pkg::ACT_POWER) begin
         if (m != 64'd0)
            o.result = mexp_pkg::RESULT_W'(power_mod(base, exponent, m));
      end else if (m < mexp_pkg::FERMAT_OFFSET) begin
         o.status = mexp_pkg::STATUS_BADMOD;
      end else begin
         o.result = mexp_pkg::RESULT_W'(power_mod(base, m - mexp_pkg::FERMAT_OFFSET, m));
      end
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t word %0d: %s", $realtime, words_checked, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_results
      outcome_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected word result=%0d status=%0d",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_tdata !== want.result)
                  report_mismatch($sformatf("result %0d, expected %0d", rsp_tdata, want.result));
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_tuser, want.status));
            end
            words_checked++;
         end
      end
   end

   // valid stays high between back-to-back words; it drops only on an idle gap or a drain
   task automatic send_word(input logic action, input logic [31:0] base,
                            input logic [63:0] exponent);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {exponent, base};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(modexp_outcome(action, base, exponent, modulus_model));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [31:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {mexp_pkg::REG_MODULUS, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register takes the value at this edge
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      modulus_model = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] random_modulus();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(2, 300);
         2: return 32'd65521;
         3: return 32'd4294967291;
         4: return 32'd998244353;
         5: return 32'hFFFF_FFFF;
         6: return $urandom_range(0, 2);
         default: return 32'h8000_0000 | $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_base();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 15);
         1: return modulus_model;
         2: return modulus_model - 32'd1;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // mostly short exponents keep the run fast; a few span all 64 bits
   function automatic logic [63:0] random_exponent();
      int          len;
      int          pick;
      logic [63:0] e;
      pick = $urandom_range(0, 99);
      if (pick < 5)
         len = 64;
      else if (pick < 15)
         len = $urandom_range(13, 40);
      else
         len = $urandom_range(0, 12);
      e = {$urandom, $urandom};
      if (len == 0) begin
         e = '0;
      end else if (len < 64) begin
         e = e & ((64'd1 << len) - 64'd1);
         e[len-1] = 1'b1;
      end
      return e;
   endfunction

   task automatic test_reset_modulus();
      send_word(mexp_pkg::ACT_POWER, 32'd0, 64'd0);
      send_word(mexp_pkg::ACT_POWER, 32'd0, 64'd5);
      send_word(mexp_pkg::ACT_POWER, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(mexp_pkg::ACT_POWER, 32'd2, 64'd1);
      send_word(mexp_pkg::ACT_POWER, 32'd123456789, 64'h8000_0000_0000_0000);
      send_word(mexp_pkg::ACT_INVERSE, 32'd2, 64'd0);
      send_word(mexp_pkg::ACT_INVERSE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(mexp_pkg::ACT_INVERSE, mexp_pkg::MODULUS_RESET, 64'd7);
   endtask

   task automatic test_degenerate_moduli();
      write_modulus(32'd1);
      send_word(mexp_pkg::ACT_POWER, 32'd5, 64'd0);
      send_word(mexp_pkg::ACT_POWER, 32'd7, 64'd12345);
      send_word(mexp_pkg::ACT_INVERSE, 32'd3, 64'd0);
      write_modulus(32'd0);
      send_word(mexp_pkg::ACT_POWER, 32'd9, 64'd3);
      send_word(mexp_pkg::ACT_INVERSE, 32'd9, 64'd3);
      // modulus 2: a base that is a multiple still comes back as 1
      write_modulus(32'd2);
      send_word(mexp_pkg::ACT_INVERSE, 32'd4, 64'd0);
      send_word(mexp_pkg::ACT_INVERSE, 32'd3, 64'd0);
      send_word(mexp_pkg::ACT_POWER, 32'd3, 64'd0);
   endtask

   task automatic test_wide_moduli();
      write_modulus(32'hFFFF_FFFF);
      send_word(mexp_pkg::ACT_POWER, 32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(mexp_pkg::ACT_INVERSE, 32'hFFFF_FFFF, 64'd0);
      write_modulus(32'd4294967291);
      send_word(mexp_pkg::ACT_INVERSE, 32'hFFFF_FFFF, 64'd0);
      send_word(mexp_pkg::ACT_INVERSE, 32'd2, 64'h5555_AAAA_5555_AAAA);
      write_modulus(32'h8000_0000);
      send_word(mexp_pkg::ACT_POWER, 32'd3, 64'h8000_0000_0000_0000);
   endtask

   task automatic test_random_traffic(input int words, input int send_pct, input int stall_pct);
      logic        action;
      logic [31:0] base;
      logic [63:0] exponent;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < words; i++) begin
         if (i % 15 == 0)
            write_modulus(random_modulus());
         action   = ($urandom_range(0, 9) < 3) ? mexp_pkg::ACT_INVERSE : mexp_pkg::ACT_POWER;
         base     = random_base();
         exponent = (action == mexp_pkg::ACT_INVERSE) ? {$urandom, $urandom}
                                                      : random_exponent();
         send_word(action, base, exponent);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_modulus();
      test_degenerate_moduli();
      test_wide_moduli();
      test_random_traffic(36, 16, 84);
      test_random_traffic(36, 84, 16);
      test_random_traffic(36, 0, 0);
      drain_results();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
